// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the PCX decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge, reset included
`define PCXD_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("pcxd assertion failed");

// check outside of reset
`define PCXD_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcxd assertion failed");

`endif

// ===== hdl/pcxd_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX decoder package
// Types and constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package pcxd_pkg;

  localparam int HdrSize = 128;
  localparam int PalSize = 769;
  localparam int MinLen  = HdrSize + PalSize;

  localparam logic [6:0] PosManufacturer = 7'd0;
  localparam logic [6:0] PosEncoding     = 7'd2;
  localparam logic [6:0] PosBits         = 7'd3;
  localparam logic [6:0] PosXMin         = 7'd4;
  localparam logic [6:0] PosPlanes       = 7'd65;
  localparam logic [6:0] PosBplLow       = 7'd66;
  localparam logic [6:0] PosBplHigh      = 7'd67;

  localparam logic [7:0] ManufacturerId = 8'h0a;
  localparam logic [7:0] EncodingRle    = 8'h01;
  localparam logic [7:0] BitsPerPixel   = 8'h08;
  localparam logic [7:0] PlaneCount     = 8'h01;
  localparam logic [7:0] PaletteMarker  = 8'h0c;
  localparam logic [1:0] RunTag         = 2'b11;

  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_FORMAT     = 4'd2,
    ST_BOUNDS     = 4'd3,
    ST_NARROW     = 4'd4,
    ST_MARKER     = 4'd5,
    ST_RUN_CUT    = 4'd6,
    ST_OVERFLOW   = 4'd7,
    ST_INCOMPLETE = 4'd8
  } status_t;

  typedef struct packed {
    logic       is_status;
    status_t    status;
    logic [7:0] pix;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [16:0] width;
    logic [15:0] bpl;
  } geom_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pix;
    logic [15:0] col;
    logic [15:0] row;
    status_t     status;
    logic        last;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ===== hdl/pcx_rle_image_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// PCX RLE image decoder
// Decodes an 8-bit single-plane PCX byte stream into pixels with positions
// and one final status result.
// ----------------------------------------------------------------------------
// The file length register must be written before the first byte. The front
// end takes one byte per cycle (header, literal, run prefix or run value)
// while the four-entry request queue is not full, so it goes on taking
// bytes while the back end still expands earlier requests. The back end
// takes each request from the queue and expands a pixel request into its
// decoded bytes (padding included, up to 63 for a run), one per cycle while
// the result is not stalled. The status result at the palette marker passes
// through the queue and the output register; the first pixel of a request
// passes through the queue, the back end's count and pixel registers and the
// output register. A stalled result holds the back end. Pixels in the line
// padding are dropped; bytes after the marker produce nothing.
module pcx_rle_image_decoder_unit #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [23:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pixel_index, col, row, status, zero pad
  output logic        m_tuser,   // kind
  output logic        m_tlast
);
  import pcxd_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head;
  geom_t   geom;
  result_t res;
  logic    push;
  logic    pop;
  logic    empty;
  logic    full;

  pcxd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .fifo_full (full),
    .push      (push),
    .cmd       (push_cmd),
    .geom      (geom)
  );

  pcxd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  pcxd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .geom    (geom),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .res     (res)
  );

  assign m_tdata = {4'd0, res.status, res.row, res.col, res.pix};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;
endmodule

// ===== hdl/pcxd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// PCX decoder command queue
// Short queue of decode commands between the front end and the back end.
// ----------------------------------------------------------------------------
module pcxd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcxd_pkg::cmd_t push_data,
  input  logic           pop,
  output pcxd_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import pcxd_pkg::*;

  cmd_t                   mem [FifoDepth];
  logic [FifoPtrBits-1:0] wptr;
  logic [FifoPtrBits-1:0] rptr;
  logic [FifoPtrBits:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (FifoPtrBits+1)'(FifoDepth));
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/pcxd_front.sv =====
// ----------------------------------------------------------------------------
// PCX decoder front end
// Tracks the byte position, parses and judges the header, splits the RLE
// stream into pixel and status requests and keeps the decoded byte count.
// ----------------------------------------------------------------------------
module pcxd_front #(
  parameter int LENGTH_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [23:0]     cfg_wdata,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            fifo_full,
  output logic            push,
  output pcxd_pkg::cmd_t  cmd,
  output pcxd_pkg::geom_t geom
);
  import pcxd_pkg::*;

  logic [23:0]            file_length;
  logic [LENGTH_BITS-1:0] pos;
  logic [15:0]            hf [5];
  logic                   format_ok;
  status_t                header_error;
  logic                   run_pending;
  logic [5:0]             run_count;
  logic [31:0]            decoded;
  status_t                first_error;
  logic [31:0]            total;

  logic [LENGTH_BITS-1:0] pos_next;
  logic [15:0]            hf_next [5];
  logic                   format_ok_next;
  status_t                header_error_next;
  logic                   run_pending_next;
  logic [5:0]             run_count_next;
  logic [31:0]            decoded_next;
  status_t                first_error_next;

  logic                   accept;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] marker;
  logic                   short_file;
  logic [6:0]             hp;
  logic [7:0]             b;
  logic [16:0]            width;
  logic [16:0]            height;
  logic [32:0]            product;
  logic [31:0]            remain;
  logic [15:0]            bpl_new;

  assign s_tready   = !fifo_full;
  assign accept     = s_tvalid && s_tready;
  assign len        = LENGTH_BITS'(file_length);
  assign marker     = len - LENGTH_BITS'(PalSize);
  assign short_file = len < LENGTH_BITS'(MinLen);
  assign hp         = pos[6:0];
  assign b          = s_tdata;
  assign width      = {1'b0, hf[2]} - {1'b0, hf[0]} + 17'd1;
  assign height     = {1'b0, hf[3]} - {1'b0, hf[1]} + 17'd1;
  assign product    = {17'b0, hf[4]} * {16'b0, height};
  assign remain     = total - decoded;
  assign bpl_new    = {b, hf[4][7:0]};

  always_comb begin
    pos_next          = pos;
    hf_next           = hf;
    format_ok_next    = format_ok;
    header_error_next = header_error;
    run_pending_next  = run_pending;
    run_count_next    = run_count;
    decoded_next      = decoded;
    first_error_next  = first_error;
    push              = 1'b0;
    cmd               = '{is_status: 1'b0, status: ST_OK, pix: b, count: 6'd1};

    if (accept) begin
      if (pos != '1) begin
        pos_next = pos + 1'b1;
      end
      if (pos < LENGTH_BITS'(HdrSize)) begin
        if ((hp == PosManufacturer && b != ManufacturerId) ||
            (hp == PosEncoding && b != EncodingRle) ||
            (hp == PosBits && b != BitsPerPixel) ||
            (hp == PosPlanes && b != PlaneCount)) begin
          format_ok_next = 1'b0;
        end
        for (int i = 0; i < 4; i++) begin
          if (hp == PosXMin + 7'(2 * i)) begin
            hf_next[i] = {hf[i][15:8], b};
          end
          if (hp == PosXMin + 7'(2 * i + 1)) begin
            hf_next[i] = {b, hf[i][7:0]};
          end
        end
        if (hp == PosBplLow) begin
          hf_next[4] = {hf[4][15:8], b};
        end
        if (hp == PosBplHigh) begin
          hf_next[4] = bpl_new;
        end
        priority if (hp == PosManufacturer && short_file) begin
          header_error_next = ST_SHORT;
          push              = 1'b1;
          cmd.is_status     = 1'b1;
          cmd.status        = ST_SHORT;
        end else if (hp == PosBplHigh && header_error == ST_OK) begin
          priority if (!format_ok) begin
            header_error_next = ST_FORMAT;
          end else if (hf[2] < hf[0] || hf[3] < hf[1]) begin
            header_error_next = ST_BOUNDS;
          end else if (bpl_new == 16'd0 || {1'b0, bpl_new} < width) begin
            header_error_next = ST_NARROW;
          end else begin
            header_error_next = ST_OK;
          end
        end else begin
          header_error_next = header_error;
        end
      end else if (!short_file && header_error != ST_SHORT) begin
        if (pos == marker) begin
          push          = 1'b1;
          cmd.is_status = 1'b1;
          priority if (header_error != ST_OK) begin
            cmd.status = header_error;
          end else if (b != PaletteMarker) begin
            cmd.status = ST_MARKER;
          end else if (first_error != ST_OK) begin
            cmd.status = first_error;
          end else if (run_pending) begin
            cmd.status = ST_RUN_CUT;
          end else if (decoded != total) begin
            cmd.status = ST_INCOMPLETE;
          end else begin
            cmd.status = ST_OK;
          end
        end else if (pos < marker && header_error == ST_OK &&
                     first_error == ST_OK && decoded < total) begin
          priority if (run_pending) begin
            run_pending_next = 1'b0;
            if ({26'b0, run_count} > remain) begin
              first_error_next = ST_OVERFLOW;
            end else begin
              push         = 1'b1;
              cmd.count    = run_count;
              decoded_next = decoded + {26'b0, run_count};
            end
          end else if (b[7:6] == RunTag) begin
            if (b[5:0] == 6'd0 || pos + 1'b1 == marker) begin
              first_error_next = ST_RUN_CUT;
            end else begin
              run_pending_next = 1'b1;
              run_count_next   = b[5:0];
            end
          end else begin
            push         = 1'b1;
            decoded_next = decoded + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length  <= '0;
      pos          <= '0;
      hf           <= '{default: '0};
      format_ok    <= 1'b1;
      header_error <= ST_OK;
      run_pending  <= 1'b0;
      run_count    <= '0;
      decoded      <= '0;
      first_error  <= ST_OK;
    end else begin
      if (cfg_wen) begin
        file_length <= cfg_wdata;
      end
      pos          <= pos_next;
      hf           <= hf_next;
      format_ok    <= format_ok_next;
      header_error <= header_error_next;
      run_pending  <= run_pending_next;
      run_count    <= run_count_next;
      decoded      <= decoded_next;
      first_error  <= first_error_next;
    end
  end

  always_ff @(posedge clk) begin
    total      <= product[31:0];
    geom.width <= width;
    geom.bpl   <= hf[4];
  end
endmodule

// ===== hdl/pcxd_back.sv =====
// ----------------------------------------------------------------------------
// PCX decoder back end
// Expands pixel requests one decoded byte per cycle unless the output stalls,
// tracks column and row, drops line padding and drives the output register.
// ----------------------------------------------------------------------------
module pcxd_back (
  input  logic              clk,
  input  logic              rst,
  input  pcxd_pkg::cmd_t    head,
  input  logic              empty,
  output logic              pop,
  input  pcxd_pkg::geom_t   geom,
  output logic              m_valid,
  input  logic              m_ready,
  output pcxd_pkg::result_t res
);
  import pcxd_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [5:0]  cnt;
  logic [7:0]  pix;
  logic [15:0] col;
  logic [15:0] row;

  logic        out_free;
  logic        step;
  logic        emit;
  logic        is_last;
  logic        wrap;
  logic [16:0] col_inc;
  logic [16:0] gap;
  logic [5:0]  rem;

  assign out_free = !m_valid || m_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop && !head.is_status) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (step && cnt == 6'd1) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state == BK_IDLE) && !empty && out_free;
    step    = (state == BK_RUN) && out_free;
    col_inc = {1'b0, col} + 17'd1;
    gap     = {1'b0, geom.bpl} - {1'b0, col};
    rem     = cnt - 6'd1;
    emit    = {1'b0, col} < geom.width;
    is_last = (rem == 6'd0) || ((col_inc >= geom.width) && ({11'b0, rem} < gap));
    wrap    = col_inc >= {1'b0, geom.bpl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      col     <= '0;
      row     <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step) begin
        col <= wrap ? 16'd0 : col_inc[15:0];
        row <= wrap ? row + 16'd1 : row;
      end
      if (out_free) begin
        m_valid <= (pop && head.is_status) || (step && emit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_status) begin
      cnt <= head.count;
      pix <= head.pix;
    end else if (step) begin
      cnt <= rem;
    end
    if (out_free) begin
      if (pop) begin
        res <= '{kind: 1'b1, pix: 8'd0, col: 16'd0, row: 16'd0,
                 status: head.status, last: 1'b1};
      end else begin
        res <= '{kind: 1'b0, pix: pix, col: col, row: row,
                 status: ST_OK, last: is_last};
      end
    end
  end
endmodule

// ===== hdl/pcxd_checker.sv =====
// ----------------------------------------------------------------------------
// PCX decoder port checker
// Watches the result stream of the decoder top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcxd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic status_clean;

  assign status_clean = m_tlast && (m_tdata[39:0] == 40'd0) && (m_tdata[43:40] <= 4'd8);

  `PCXD_ASSERT_CLK(a_reset_clears_out, clk, rst |=> !m_tvalid)

  `PCXD_ASSERT_RST(a_stall_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid)

  `PCXD_ASSERT_RST(a_status_form, clk, rst, m_tvalid && m_tuser |-> status_clean)

  `PCXD_ASSERT_RST(a_pixel_form, clk, rst, m_tvalid && !m_tuser |-> m_tdata[47:40] == 8'd0)

endmodule

bind pcx_rle_image_decoder_unit pcxd_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX RLE image decoder testbench
// Streams one PCX file through the decoder: a header of random geometry
// (now and then a broken one), a table of directed requests, random
// well-formed RLE phases, and one closing phase that ends in a run error, a
// full image or noise. The file length is moved between phases so that a
// palette marker falls at the end of each. Every accepted request is run
// through a local model of the decoder, and each result is checked field by
// field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
  import pcxd_pkg::*;

  localparam int LenBits = 24;
  localparam logic [23:0] PosMax = 24'hffffff;
  localparam int DrainGap = 80;
  localparam int TailCycles = 100;
  localparam int CycleLimit = 400000;
  localparam int RandomItems = 185;
  localparam int MaxPrinted = 30;
  localparam int NumDir = 23;

  typedef enum logic [1:0] {OP_BYTE, OP_LEN, OP_RAW_LEN} row_op_t;
  typedef enum logic [2:0] {
    HDR_CLEAN, HDR_FORMAT, HDR_BOUNDS, HDR_NARROW, HDR_SHORT
  } hdr_case_t;
  typedef enum logic [2:0] {
    END_FULL, END_OVERFLOW, END_ZERO_RUN, END_CUT, END_NOISE
  } end_case_t;

  typedef struct packed {
    row_op_t     op;
    logic [23:0] val;
    logic        fixed;
    status_t     st;
  } step_t;

  // OP_LEN places the marker after val more data bytes
  step_t dir_tbl [NumDir] = '{
    '{OP_RAW_LEN, 24'h0,  1'b0, ST_OK},
    '{OP_BYTE,    24'h00, 1'b0, ST_OK},
    '{OP_LEN,     24'd6,  1'b0, ST_OK},
    '{OP_BYTE,    24'h00, 1'b0, ST_OK},
    '{OP_BYTE,    24'hbf, 1'b0, ST_OK},
    '{OP_BYTE,    24'h7f, 1'b0, ST_OK},
    '{OP_BYTE,    24'hc1, 1'b0, ST_OK},
    '{OP_BYTE,    24'hff, 1'b0, ST_OK},
    '{OP_BYTE,    24'h3c, 1'b0, ST_OK},
    '{OP_BYTE,    24'h0c, 1'b1, ST_INCOMPLETE},
    '{OP_BYTE,    24'h0c, 1'b0, ST_OK},
    '{OP_LEN,     24'd2,  1'b0, ST_OK},
    '{OP_BYTE,    24'hff, 1'b0, ST_OK},
    '{OP_BYTE,    24'ha5, 1'b0, ST_OK},
    '{OP_BYTE,    24'h0d, 1'b1, ST_MARKER},
    '{OP_LEN,     24'd3,  1'b0, ST_OK},
    '{OP_BYTE,    24'hc4, 1'b0, ST_OK},
    '{OP_LEN,     24'd0,  1'b0, ST_OK},
    '{OP_BYTE,    24'h0c, 1'b1, ST_RUN_CUT},
    '{OP_LEN,     24'd2,  1'b0, ST_OK},
    '{OP_BYTE,    24'h80, 1'b0, ST_OK},
    '{OP_BYTE,    24'h40, 1'b0, ST_OK},
    '{OP_BYTE,    24'h0c, 1'b1, ST_INCOMPLETE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // decoder model state
  logic [23:0] flen;
  logic [23:0] pos_q;
  logic [15:0] geo [5];
  logic        fmt_ok;
  status_t     hdr_err;
  status_t     run_err;
  logic        run_wait;
  logic [5:0]  run_len;
  logic [31:0] pix_done;
  logic [15:0] col_q;
  logic [15:0] row_q;

  result_t     step_res [$];
  result_t     pend_q [$];

  int unsigned errors = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycles = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;

  pcx_rle_image_decoder_unit #(
    .LENGTH_BITS(LenBits)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL pcx_rle_image_decoder_unit");
      $finish;
    end
  end

  function automatic logic [31:0] img_width();
    return {16'd0, geo[2]} - {16'd0, geo[0]} + 32'd1;
  endfunction

  function automatic logic [31:0] img_total();
    logic [31:0] h;
    logic [63:0] t;
    h = {16'd0, geo[3]} - {16'd0, geo[1]} + 32'd1;
    t = {48'd0, geo[4]} * {32'd0, h};
    return t[31:0];
  endfunction

  function automatic result_t status_res(status_t st);
    return '{kind: 1'b1, pix: 8'd0, col: 16'd0, row: 16'd0, status: st, last: 1'b1};
  endfunction

  task automatic clear_model();
    flen = '0;
    pos_q = '0;
    foreach (geo[i]) geo[i] = '0;
    fmt_ok = 1'b1;
    hdr_err = ST_OK;
    run_err = ST_OK;
    run_wait = 1'b0;
    run_len = '0;
    pix_done = '0;
    col_q = '0;
    row_q = '0;
  endtask

  task automatic emit_pixels(input int unsigned count, input logic [7:0] pix);
    result_t r;
    int unsigned n;
    n = 0;
    if (count > img_total() - pix_done) begin
      run_err = ST_OVERFLOW;
      return;
    end
    for (int unsigned i = 0; i < count; i++) begin
      if ({16'd0, col_q} < img_width()) begin
        r = '{kind: 1'b0, pix: pix, col: col_q, row: row_q, status: ST_OK, last: 1'b0};
        step_res.push_back(r);
        n++;
      end
      pix_done++;
      col_q++;
      if (col_q >= geo[4]) begin
        col_q = '0;
        row_q++;
      end
    end
    if (n > 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [23:0] p;
    logic [23:0] marker;
    int unsigned idx;
    status_t st;
    step_res.delete();
    p = pos_q;
    if (p < PosMax) pos_q = p + 24'd1;
    if (p < HdrSize) begin
      if ((p == PosManufacturer && b != ManufacturerId) ||
          (p == PosEncoding && b != EncodingRle) ||
          (p == PosBits && b != BitsPerPixel) ||
          (p == PosPlanes && b != PlaneCount))
        fmt_ok = 1'b0;
      if (p >= PosXMin && p <= 24'(PosXMin) + 24'd7) begin
        idx = int'((p - 24'(PosXMin)) >> 1);
        if (p[0]) geo[idx][15:8] = b;
        else geo[idx][7:0] = b;
      end
      if (p == PosBplLow) geo[4][7:0] = b;
      if (p == PosBplHigh) geo[4][15:8] = b;
      if (p == PosManufacturer && flen < MinLen) begin
        hdr_err = ST_SHORT;
        step_res.push_back(status_res(ST_SHORT));
        return;
      end
      if (p == PosBplHigh && hdr_err == ST_OK) begin
        if (!fmt_ok) hdr_err = ST_FORMAT;
        else if (geo[2] < geo[0] || geo[3] < geo[1]) hdr_err = ST_BOUNDS;
        else if (geo[4] == 0 || {16'd0, geo[4]} < img_width()) hdr_err = ST_NARROW;
      end
      return;
    end
    if (flen < MinLen || hdr_err == ST_SHORT) return;
    marker = flen - 24'(PalSize);
    if (p == marker) begin
      if (hdr_err != ST_OK) st = hdr_err;
      else if (b != PaletteMarker) st = ST_MARKER;
      else if (run_err != ST_OK) st = run_err;
      else if (run_wait) st = ST_RUN_CUT;
      else if (pix_done != img_total()) st = ST_INCOMPLETE;
      else st = ST_OK;
      step_res.push_back(status_res(st));
      return;
    end
    if (p > marker || hdr_err != ST_OK) return;
    if (run_err != ST_OK || pix_done >= img_total()) return;
    if (run_wait) begin
      run_wait = 1'b0;
      emit_pixels(32'(run_len), b);
    end else if (b[7:6] == RunTag) begin
      if (b[5:0] == 6'd0 || {8'd0, p} + 32'd1 >= {8'd0, marker}) begin
        run_err = ST_RUN_CUT;
      end else begin
        run_wait = 1'b1;
        run_len = b[5:0];
      end
    end else begin
      emit_pixels(1, b);
    end
  endtask

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] literal_byte();
    return {2'($urandom_range(0, 2)), 6'($urandom)};
  endfunction

  function automatic logic [7:0] run_byte();
    int unsigned c;
    c = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
    return {RunTag, 6'(c)};
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    errors++;
    if (errors <= MaxPrinted)
      $display("mismatch %0s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pend_q.size() == 0) begin
      note_mismatch("unexpected result, status", got.status, 0);
      return;
    end
    want = pend_q.pop_front();
    if (got.kind != want.kind) note_mismatch("kind", got.kind, want.kind);
    if (got.pix != want.pix) note_mismatch("pixel_index", got.pix, want.pix);
    if (got.col != want.col) note_mismatch("col", got.col, want.col);
    if (got.row != want.row) note_mismatch("row", got.row, want.row);
    if (got.status != want.status) note_mismatch("status", got.status, want.status);
    if (got.last != want.last) note_mismatch("last", got.last, want.last);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fixed, input status_t st);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_cnt++;
    predict_byte(b);
    if (fixed) begin
      pend_q.push_back(status_res(st));
    end else begin
      foreach (step_res[i]) pend_q.push_back(step_res[i]);
    end
  endtask

  // drain, let the back end settle, then write
  task automatic write_length(input logic [23:0] v);
    s_tvalid <= 1'b0;
    while (pend_q.size() != 0) @(posedge clk);
    repeat (DrainGap) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    flen = v;
  endtask

  task automatic set_marker(input int unsigned n);
    write_length(pos_q + 24'(n) + 24'(PalSize));
  endtask

  task automatic send_header(input hdr_case_t hc);
    logic [7:0] hdr [HdrSize];
    logic [15:0] w, bpl, h, xmin, ymin, xmax, ymax;
    int unsigned k;
    logic [23:0] len;
    w = 16'($urandom_range(2, 12));
    bpl = w + 16'($urandom_range(0, 3));
    h = 16'(300 / bpl) + 16'($urandom_range(0, 300 / bpl));
    case ($urandom_range(0, 3))
      0: xmin = 16'd0;
      1: xmin = 16'hffff - w + 16'd1;
      default: xmin = 16'($urandom_range(0, 65536 - w));
    endcase
    case ($urandom_range(0, 3))
      0: ymin = 16'd0;
      1: ymin = 16'hffff - h + 16'd1;
      default: ymin = 16'($urandom_range(0, 65536 - h));
    endcase
    xmax = xmin + w - 16'd1;
    ymax = ymin + h - 16'd1;
    if (hc == HDR_BOUNDS) begin
      if ($urandom_range(0, 1) == 1) begin
        xmin = 16'($urandom_range(1, 65535));
        xmax = 16'($urandom_range(0, xmin - 1));
      end else begin
        ymin = 16'($urandom_range(1, 65535));
        ymax = 16'($urandom_range(0, ymin - 1));
      end
    end
    if (hc == HDR_NARROW) bpl = ($urandom_range(0, 1) == 1) ? 16'd0 : w - 16'd1;
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[PosManufacturer] = ManufacturerId;
    hdr[PosEncoding] = EncodingRle;
    hdr[PosBits] = BitsPerPixel;
    hdr[PosPlanes] = PlaneCount;
    {hdr[5], hdr[4]} = xmin;
    {hdr[7], hdr[6]} = ymin;
    {hdr[9], hdr[8]} = xmax;
    {hdr[11], hdr[10]} = ymax;
    {hdr[PosBplHigh], hdr[PosBplLow]} = bpl;
    if (hc == HDR_FORMAT) begin
      case ($urandom_range(0, 3))
        0: k = PosManufacturer;
        1: k = PosEncoding;
        2: k = PosBits;
        default: k = PosPlanes;
      endcase
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end
    if (hc != HDR_SHORT) len = PosMax;
    else if ($urandom_range(0, 1) == 1) len = 24'($urandom_range(0, MinLen - 1));
    else len = ($urandom_range(0, 1) == 1) ? 24'd0 : 24'(MinLen - 1);
    write_length(len);
    foreach (hdr[i]) send_byte(hdr[i], 1'b0, ST_OK);
  endtask

  task automatic run_phase();
    logic [7:0] seq [$];
    int unsigned n;
    n = $urandom_range(2, 14);
    while (seq.size() < n) begin
      if (seq.size() + 1 < n && $urandom_range(0, 3) == 0) begin
        seq.push_back(run_byte());
        seq.push_back(8'($urandom));
      end else begin
        seq.push_back(literal_byte());
      end
    end
    set_marker(seq.size());
    foreach (seq[i]) send_byte(seq[i], 1'b0, ST_OK);
    send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : PaletteMarker, 1'b0, ST_OK);
  endtask

  task automatic end_phase();
    logic [7:0] seq [$];
    logic [31:0] rem, keep, c;
    end_case_t ec;
    ec = end_case_t'($urandom_range(0, 4));
    rem = (hdr_err == ST_OK && run_err == ST_OK && !run_wait) ? img_total() - pix_done : 0;
    if (ec == END_FULL) keep = 0;
    else keep = (rem < 10) ? rem : $urandom_range(0, 10);
    rem = rem - keep;
    while (rem > 0) begin
      c = (rem > 63) ? 63 : rem;
      if (c == 1) begin
        seq.push_back(literal_byte());
      end else begin
        seq.push_back({RunTag, 6'(c)});
        seq.push_back(8'($urandom));
      end
      rem = rem - c;
    end
    case (ec)
      END_FULL: seq.push_back(literal_byte());
      END_OVERFLOW: begin
        seq.push_back({RunTag, 6'($urandom_range(keep + 1, 63))});
        seq.push_back(8'($urandom));
      end
      END_ZERO_RUN: begin
        seq.push_back({RunTag, 6'd0});
        seq.push_back(literal_byte());
      end
      END_CUT: seq.push_back(run_byte());
      default: repeat ($urandom_range(4, 10)) seq.push_back(8'($urandom));
    endcase
    set_marker(seq.size());
    foreach (seq[i]) send_byte(seq[i], 1'b0, ST_OK);
    if (ec == END_NOISE && $urandom_range(0, 1) == 1) send_byte(8'($urandom), 1'b0, ST_OK);
    else send_byte(PaletteMarker, 1'b0, ST_OK);
    repeat (2) send_byte(8'($urandom), 1'b0, ST_OK);
    set_marker(3);
    repeat (3) send_byte(literal_byte(), 1'b0, ST_OK);
    send_byte(PaletteMarker, 1'b0, ST_OK);
  endtask

  initial begin : result_sink
    result_t got;
    int unsigned hold;
    logic fire;
    hold = 0;
    forever begin
      @(posedge clk);
      fire = m_tvalid && m_tready && !rst;
      got = '{kind: m_tuser, pix: m_tdata[7:0], col: m_tdata[23:8], row: m_tdata[39:24],
              status: status_t'(m_tdata[43:40]), last: m_tlast};
      if (hold > 0) hold--;
      else hold = pick_gap(rx_calm);
      m_tready <= (hold == 0);
      if (fire) begin
        #1;
        check_result(got);
      end
    end
  end

  initial begin : request_source
    hdr_case_t hc;
    int unsigned r;
    logic clean;
    clear_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    r = $urandom_range(0, 99);
    if (r < 76) hc = HDR_CLEAN;
    else if (r < 82) hc = HDR_FORMAT;
    else if (r < 88) hc = HDR_BOUNDS;
    else if (r < 94) hc = HDR_NARROW;
    else hc = HDR_SHORT;
    clean = (hc == HDR_CLEAN);
    send_header(hc);
    foreach (dir_tbl[i]) begin
      case (dir_tbl[i].op)
        OP_RAW_LEN: write_length(dir_tbl[i].val);
        OP_LEN: set_marker(dir_tbl[i].val);
        default: send_byte(dir_tbl[i].val[7:0], dir_tbl[i].fixed && clean, dir_tbl[i].st);
      endcase
    end
    while (sent_cnt < RandomItems) run_phase();
    end_phase();
    s_tvalid <= 1'b0;
    while (pend_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && pend_q.size() == 0) begin
      $display("PASS pcx_rle_image_decoder_unit");
    end else begin
      $display("FAIL pcx_rle_image_decoder_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pcxd_pkg.sv
hdl/pcxd_cmd_fifo.sv
hdl/pcxd_front.sv
hdl/pcxd_back.sv
hdl/pcx_rle_image_decoder_unit.sv
hdl/pcxd_checker.sv
tb/sv/tb_top.sv
